>>> sv/ipt_pkg.sv
// shared constants and control types for the inverted page table
package ipt_pkg;

	// port widths of the transaction fields
	localparam int PAGE_W  = 16;
	localparam int OWNER_W = 8;
	localparam int TICK_W  = 32;
	localparam int FRAME_W = 5;

	// default table geometry
	localparam int FRAMES_DEF     = 32;
	localparam int PAGE_BITS_DEF  = 16;
	localparam int OWNER_BITS_DEF = 8;

	// control flags of the search token that walks the cell chain
	typedef struct packed {
		logic valid;
		logic hit_found;
		logic free_found;
		logic best_valid;
	} tok_flags_t;

endpackage

>>> sv/ipt_cell.sv
// one table entry with its stage of the search chain
module ipt_cell #(
	parameter int IDX        = 0,
	parameter int FRAMES     = ipt_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = ipt_pkg::PAGE_BITS_DEF,
	parameter int OWNER_BITS = ipt_pkg::OWNER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ipt_pkg::tok_flags_t          flags_i,
	input  logic [PAGE_BITS-1:0]         page_i,
	input  logic [OWNER_BITS-1:0]        owner_i,
	input  logic [ipt_pkg::TICK_W-1:0]   now_i,
	input  logic [$clog2(FRAMES)-1:0]    hit_idx_i,
	input  logic [$clog2(FRAMES)-1:0]    free_idx_i,
	input  logic [ipt_pkg::TICK_W-1:0]   best_tick_i,
	input  logic [$clog2(FRAMES)-1:0]    best_idx_i,
	input  logic [PAGE_BITS-1:0]         best_page_i,
	input  logic [OWNER_BITS-1:0]        best_owner_i,
	output ipt_pkg::tok_flags_t          flags_o,
	output logic [PAGE_BITS-1:0]         page_o,
	output logic [OWNER_BITS-1:0]        owner_o,
	output logic [ipt_pkg::TICK_W-1:0]   now_o,
	output logic [$clog2(FRAMES)-1:0]    hit_idx_o,
	output logic [$clog2(FRAMES)-1:0]    free_idx_o,
	output logic [ipt_pkg::TICK_W-1:0]   best_tick_o,
	output logic [$clog2(FRAMES)-1:0]    best_idx_o,
	output logic [PAGE_BITS-1:0]         best_page_o,
	output logic [OWNER_BITS-1:0]        best_owner_o,
	input  logic                         wr_en,
	input  logic [$clog2(FRAMES)-1:0]    wr_idx
);

	localparam int IDX_W = $clog2(FRAMES);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic                       valid_q;
	logic [PAGE_BITS-1:0]       page_q;
	logic [OWNER_BITS-1:0]      owner_q;
	logic [ipt_pkg::TICK_W-1:0] tick_q;

	ipt_pkg::tok_flags_t        flags_q;
	logic [PAGE_BITS-1:0]       tpage_q;
	logic [OWNER_BITS-1:0]      towner_q;
	logic [ipt_pkg::TICK_W-1:0] tnow_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic [ipt_pkg::TICK_W-1:0] best_tick_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [PAGE_BITS-1:0]       best_page_q;
	logic [OWNER_BITS-1:0]      best_owner_q;

	logic match;
	logic take_hit;
	logic take_free;
	logic take_best;
	logic wr_me;

	assign match     = valid_q && (page_q == page_i) && (owner_q == owner_i);
	assign take_hit  = !flags_i.hit_found && match;
	assign take_free = !flags_i.free_found && !valid_q;
	// strict less keeps the lower frame on a tie
	assign take_best = !flags_i.best_valid || (tick_q < best_tick_i);
	assign wr_me     = wr_en && (wr_idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			if (wr_me) begin
				valid_q <= 1'b1;
			end
			flags_q.valid      <= flags_i.valid;
			flags_q.hit_found  <= flags_i.hit_found || match;
			flags_q.free_found <= flags_i.free_found || !valid_q;
			flags_q.best_valid <= 1'b1;
		end
	end

	// entry contents, written with the request that leaves the chain
	always_ff @(posedge clk) begin
		if (wr_me) begin
			page_q  <= page_o;
			owner_q <= owner_o;
			tick_q  <= now_o;
		end
	end

	always_ff @(posedge clk) begin
		tpage_q    <= page_i;
		towner_q   <= owner_i;
		tnow_q     <= now_i;
		hit_idx_q  <= take_hit ? MY_IDX : hit_idx_i;
		free_idx_q <= take_free ? MY_IDX : free_idx_i;
		if (take_best) begin
			best_tick_q  <= tick_q;
			best_idx_q   <= MY_IDX;
			best_page_q  <= page_q;
			best_owner_q <= owner_q;
		end else begin
			best_tick_q  <= best_tick_i;
			best_idx_q   <= best_idx_i;
			best_page_q  <= best_page_i;
			best_owner_q <= best_owner_i;
		end
	end

	assign flags_o      = flags_q;
	assign page_o       = tpage_q;
	assign owner_o      = towner_q;
	assign now_o        = tnow_q;
	assign hit_idx_o    = hit_idx_q;
	assign free_idx_o   = free_idx_q;
	assign best_tick_o  = best_tick_q;
	assign best_idx_o   = best_idx_q;
	assign best_page_o  = best_page_q;
	assign best_owner_o = best_owner_q;

endmodule

>>> sv/inverted_page_table_lru.sv
// top level: inverted page table with least-recently-used replacement
//
// Each frame is one cell of a chain. An accepted request becomes a search token that
// walks the chain one cell per cycle, collecting the first matching frame, the lowest
// free frame and the oldest entry. When it leaves the last cell the result is
// registered and the chosen entry is written in the same edge. Busy falls at that
// edge and the result strobe done rises with it; until then no new request is taken,
// so only one search token is in the chain at a time. Results are shown for one
// cycle on done and cannot be stalled. Valid marks clear at reset; no clearing pass
// is needed.
module inverted_page_table_lru #(
	parameter int FRAMES     = ipt_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = ipt_pkg::PAGE_BITS_DEF,
	parameter int OWNER_BITS = ipt_pkg::OWNER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ipt_pkg::PAGE_W-1:0]   page_number,
	input  logic [ipt_pkg::OWNER_W-1:0]  thread_id,
	input  logic [ipt_pkg::TICK_W-1:0]   now_tick,
	output logic                         done,
	output logic                         hit,
	output logic [ipt_pkg::FRAME_W-1:0]  frame,
	output logic                         evicted,
	output logic [ipt_pkg::PAGE_W-1:0]   victim_page,
	output logic [ipt_pkg::OWNER_W-1:0]  victim_owner
);

	localparam int IDX_W = $clog2(FRAMES);
	localparam int TW    = ipt_pkg::TICK_W;
	localparam int PW    = ipt_pkg::PAGE_W;
	localparam int OW    = ipt_pkg::OWNER_W;
	localparam int FW    = ipt_pkg::FRAME_W;

	ipt_pkg::tok_flags_t   fl     [FRAMES+1];
	logic [PAGE_BITS-1:0]  pg     [FRAMES+1];
	logic [OWNER_BITS-1:0] ow     [FRAMES+1];
	logic [TW-1:0]         nw     [FRAMES+1];
	logic [IDX_W-1:0]      hidx   [FRAMES+1];
	logic [IDX_W-1:0]      fidx   [FRAMES+1];
	logic [TW-1:0]         btick  [FRAMES+1];
	logic [IDX_W-1:0]      bidx   [FRAMES+1];
	logic [PAGE_BITS-1:0]  bpage  [FRAMES+1];
	logic [OWNER_BITS-1:0] bowner [FRAMES+1];

	logic                  busy_q;
	logic                  inj_valid_q;
	logic [PAGE_BITS-1:0]  inj_page_q;
	logic [OWNER_BITS-1:0] inj_owner_q;
	logic [TW-1:0]         inj_now_q;

	logic                  done_q;
	logic                  hit_q;
	logic [FW-1:0]         frame_q;
	logic                  evicted_q;
	logic [PW-1:0]         victim_page_q;
	logic [OW-1:0]         victim_owner_q;

	logic                  accept;
	logic                  fin;
	logic                  fin_evict;
	logic [IDX_W-1:0]      slot;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			inj_valid_q <= 1'b0;
		end else begin
			inj_valid_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inj_page_q  <= PAGE_BITS'(page_number);
			inj_owner_q <= OWNER_BITS'(thread_id);
			inj_now_q   <= now_tick;
		end
	end

	// head of the chain: a fresh token with nothing found yet
	always_comb begin
		fl[0].valid      = inj_valid_q;
		fl[0].hit_found  = 1'b0;
		fl[0].free_found = 1'b0;
		fl[0].best_valid = 1'b0;
		pg[0]            = inj_page_q;
		ow[0]            = inj_owner_q;
		nw[0]            = inj_now_q;
		hidx[0]          = '0;
		fidx[0]          = '0;
		btick[0]         = '0;
		bidx[0]          = '0;
		bpage[0]         = '0;
		bowner[0]        = '0;
	end

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		ipt_cell #(
			.IDX        (i),
			.FRAMES     (FRAMES),
			.PAGE_BITS  (PAGE_BITS),
			.OWNER_BITS (OWNER_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.flags_i      (fl[i]),
			.page_i       (pg[i]),
			.owner_i      (ow[i]),
			.now_i        (nw[i]),
			.hit_idx_i    (hidx[i]),
			.free_idx_i   (fidx[i]),
			.best_tick_i  (btick[i]),
			.best_idx_i   (bidx[i]),
			.best_page_i  (bpage[i]),
			.best_owner_i (bowner[i]),
			.flags_o      (fl[i+1]),
			.page_o       (pg[i+1]),
			.owner_o      (ow[i+1]),
			.now_o        (nw[i+1]),
			.hit_idx_o    (hidx[i+1]),
			.free_idx_o   (fidx[i+1]),
			.best_tick_o  (btick[i+1]),
			.best_idx_o   (bidx[i+1]),
			.best_page_o  (bpage[i+1]),
			.best_owner_o (bowner[i+1]),
			.wr_en        (fin),
			.wr_idx       (slot)
		);
	end

	// tail of the chain: pick the frame and write it back
	assign fin       = fl[FRAMES].valid;
	assign fin_evict = !fl[FRAMES].hit_found && !fl[FRAMES].free_found;

	always_comb begin
		priority if (fl[FRAMES].hit_found) begin
			slot = hidx[FRAMES];
		end else if (fl[FRAMES].free_found) begin
			slot = fidx[FRAMES];
		end else begin
			slot = bidx[FRAMES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			hit_q          <= fl[FRAMES].hit_found;
			frame_q        <= FW'(slot);
			evicted_q      <= fin_evict;
			victim_page_q  <= fin_evict ? PW'(bpage[FRAMES]) : '0;
			victim_owner_q <= fin_evict ? OW'(bowner[FRAMES]) : '0;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign hit          = hit_q;
	assign frame        = frame_q;
	assign evicted      = evicted_q;
	assign victim_page  = victim_page_q;
	assign victim_owner = victim_owner_q;

endmodule

>>> sv/ipt_checker.sv
// port-level checks for the inverted page table, bound to the top level
module ipt_port_checks (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [ipt_pkg::PAGE_W-1:0]   page_number,
	input logic [ipt_pkg::OWNER_W-1:0]  thread_id,
	input logic [ipt_pkg::TICK_W-1:0]   now_tick,
	input logic                         done,
	input logic                         hit,
	input logic [ipt_pkg::FRAME_W-1:0]  frame,
	input logic                         evicted,
	input logic [ipt_pkg::PAGE_W-1:0]   victim_page,
	input logic [ipt_pkg::OWNER_W-1:0]  victim_owner
);

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	// a result only appears once the search has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one result per transaction: never two strobes in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back to back result strobes");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evicted)
		else $error("eviction reported on a hit");

	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted |-> (victim_page == '0) && (victim_owner == '0))
		else $error("victim fields set without eviction");

endmodule

bind inverted_page_table_lru ipt_port_checks u_ipt_port_checks (.*);

>>> bench/ipt_checker.sv
`timescale 1ns / 100ps
// checker for the inverted page table: predicts every lookup and compares the results
module ipt_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [ipt_pkg::PAGE_W-1:0]   page_number,
	input  logic [ipt_pkg::OWNER_W-1:0]  thread_id,
	input  logic [ipt_pkg::TICK_W-1:0]   now_tick,
	input  logic                         done,
	input  logic                         hit,
	input  logic [ipt_pkg::FRAME_W-1:0]  frame,
	input  logic                         evicted,
	input  logic [ipt_pkg::PAGE_W-1:0]   victim_page,
	input  logic [ipt_pkg::OWNER_W-1:0]  victim_owner,
	output int                           errors,
	output int                           pending,
	output int                           hits_seen,
	output int                           evictions_seen
);

	localparam int TABLE_FRAMES = ipt_pkg::FRAMES_DEF;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic                        hit;
		logic [ipt_pkg::FRAME_W-1:0] frame;
		logic                        evicted;
		logic [ipt_pkg::PAGE_W-1:0]  vpage;
		logic [ipt_pkg::OWNER_W-1:0] vowner;
	} xlate_t;

	// shadow copy of the table
	logic                        frame_used  [TABLE_FRAMES];
	logic [ipt_pkg::PAGE_W-1:0]  frame_page  [TABLE_FRAMES];
	logic [ipt_pkg::OWNER_W-1:0] frame_owner [TABLE_FRAMES];
	logic [ipt_pkg::TICK_W-1:0]  frame_tick  [TABLE_FRAMES];

	xlate_t translations_due[$];
	xlate_t want;

	task automatic report_error(input string msg);
		if (errors < PRINT_CAP)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// match, else lowest free frame, else oldest tick with the lowest frame on a tie
	function automatic xlate_t translate(input logic [ipt_pkg::PAGE_W-1:0] pg,
			input logic [ipt_pkg::OWNER_W-1:0] tid, input logic [ipt_pkg::TICK_W-1:0] tick);
		xlate_t r;
		int slot;
		logic [ipt_pkg::TICK_W-1:0] oldest;
		r = '0;
		slot = -1;
		for (int i = 0; i < TABLE_FRAMES; i++)
			if (slot < 0 && frame_used[i] && frame_page[i] == pg && frame_owner[i] == tid)
				slot = i;
		if (slot >= 0) begin
			r.hit = 1'b1;
			frame_tick[slot] = tick;
		end else begin
			for (int i = 0; i < TABLE_FRAMES; i++)
				if (slot < 0 && !frame_used[i])
					slot = i;
			if (slot < 0) begin
				slot = 0;
				oldest = frame_tick[0];
				for (int i = 1; i < TABLE_FRAMES; i++)
					if (frame_tick[i] < oldest) begin
						oldest = frame_tick[i];
						slot = i;
					end
				r.evicted = 1'b1;
				r.vpage = frame_page[slot];
				r.vowner = frame_owner[slot];
			end
			frame_used[slot] = 1'b1;
			frame_page[slot] = pg;
			frame_owner[slot] = tid;
			frame_tick[slot] = tick;
		end
		r.frame = slot[ipt_pkg::FRAME_W-1:0];
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		hits_seen = 0;
		evictions_seen = 0;
		for (int i = 0; i < TABLE_FRAMES; i++)
			frame_used[i] = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_FRAMES; i++)
				frame_used[i] = 1'b0;
			translations_due.delete();
		end else begin
			// a result leaving at this edge belongs to an earlier transaction
			if (done) begin
				if (translations_due.size() == 0) begin
					report_error("result strobe with no transaction outstanding");
				end else begin
					want = translations_due.pop_front();
					if (hit !== want.hit)
						report_error($sformatf("hit: got %b, expected %b", hit, want.hit));
					if (frame !== want.frame)
						report_error($sformatf("frame: got %0d, expected %0d",
							frame, want.frame));
					if (evicted !== want.evicted)
						report_error($sformatf("evicted: got %b, expected %b",
							evicted, want.evicted));
					if (victim_page !== want.vpage)
						report_error($sformatf("victim_page: got %h, expected %h",
							victim_page, want.vpage));
					if (victim_owner !== want.vowner)
						report_error($sformatf("victim_owner: got %h, expected %h",
							victim_owner, want.vowner));
					if (want.hit)
						hits_seen++;
					if (want.evicted)
						evictions_seen++;
				end
			end
			if (start && !busy)
				translations_due.push_back(translate(page_number, thread_id, now_tick));
		end
		pending = translations_due.size();
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// testbench top: drives page references into the inverted page table and gives the verdict
module tb;

	localparam int RUN_ITEMS    = 550;
	localparam int POOL_SIZE    = 40;
	localparam int STEP_MAX     = 1000;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = ipt_pkg::FRAMES_DEF + 10;
	localparam int PW           = ipt_pkg::PAGE_W;
	localparam int OW           = ipt_pkg::OWNER_W;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [ipt_pkg::PAGE_W-1:0]   page_number;
	logic [ipt_pkg::OWNER_W-1:0]  thread_id;
	logic [ipt_pkg::TICK_W-1:0]   now_tick;
	logic                         done;
	logic                         hit;
	logic [ipt_pkg::FRAME_W-1:0]  frame;
	logic                         evicted;
	logic [ipt_pkg::PAGE_W-1:0]   victim_page;
	logic [ipt_pkg::OWNER_W-1:0]  victim_owner;

	int errors, pending, hits_seen, evictions_seen;
	int cycles;
	int burst_left;
	int hold_left;
	int hot_size;
	int sent;

	logic [ipt_pkg::TICK_W-1:0]  user_tick;
	logic [ipt_pkg::PAGE_W-1:0]  ws_page  [POOL_SIZE];
	logic [ipt_pkg::OWNER_W-1:0] ws_owner [POOL_SIZE];

	inverted_page_table_lru DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.page_number  (page_number),
		.thread_id    (thread_id),
		.now_tick     (now_tick),
		.done         (done),
		.hit          (hit),
		.frame        (frame),
		.evicted      (evicted),
		.victim_page  (victim_page),
		.victim_owner (victim_owner)
	);

	ipt_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.page_number    (page_number),
		.thread_id      (thread_id),
		.now_tick       (now_tick),
		.done           (done),
		.hit            (hit),
		.frame          (frame),
		.evicted        (evicted),
		.victim_page    (victim_page),
		.victim_owner   (victim_owner),
		.errors         (errors),
		.pending        (pending),
		.hits_seen      (hits_seen),
		.evictions_seen (evictions_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, and now and then a back-to-back stretch
	task automatic idle_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7, 8: gap = $urandom_range(1, 4);
				default: gap = $urandom_range(20, 70);
			endcase
			if ($urandom_range(0, 39) == 0)
				burst_left = $urandom_range(10, 30);
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			page_number <= PW'($urandom);
			thread_id <= OW'($urandom);
			now_tick <= $urandom;
		end
	endtask

	task automatic send_request(input logic [ipt_pkg::PAGE_W-1:0] pg,
			input logic [ipt_pkg::OWNER_W-1:0] tid, input logic [ipt_pkg::TICK_W-1:0] tick);
		idle_gap();
		@(negedge clk);
		start <= 1'b1;
		page_number <= pg;
		thread_id <= tid;
		now_tick <= tick;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// mostly a rising clock; runs of equal ticks, rare jumps and a trip past the wrap
	function automatic logic [ipt_pkg::TICK_W-1:0] advance_tick();
		if (hold_left > 0) begin
			hold_left--;
			return user_tick;
		end
		case ($urandom_range(0, 49))
			0, 1, 2: ;
			3: hold_left = $urandom_range(2, 8);
			4: user_tick = $urandom;
			5: user_tick = 32'hFFFF_FFFF - $urandom_range(0, 3 * STEP_MAX);
			default: user_tick = user_tick + $urandom_range(1, STEP_MAX);
		endcase
		return user_tick;
	endfunction

	task automatic random_request();
		int idx;
		logic [ipt_pkg::TICK_W-1:0] tick;
		tick = advance_tick();
		case ($urandom_range(0, 19))
			0, 1: send_request(PW'($urandom), OW'($urandom), tick);
			// known page under another thread
			2, 3: send_request(ws_page[$urandom_range(0, POOL_SIZE - 1)], OW'($urandom), tick);
			default: begin
				if ($urandom_range(0, 3) == 0)
					idx = $urandom_range(0, POOL_SIZE - 1);
				else
					idx = $urandom_range(0, hot_size - 1);
				send_request(ws_page[idx], ws_owner[idx], tick);
			end
		endcase
		if ($urandom_range(0, 19) == 0) begin
			idx = $urandom_range(4, POOL_SIZE - 1);
			ws_page[idx] = PW'($urandom);
			ws_owner[idx] = OW'($urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		page_number = '0;
		thread_id = '0;
		now_tick = '0;
		burst_left = 0;
		hold_left = 0;
		sent = 0;
		user_tick = $urandom_range(0, 100000);
		ws_page[0] = 16'h0000;  ws_owner[0] = 8'h00;
		ws_page[1] = 16'hFFFF;  ws_owner[1] = 8'hFF;
		ws_page[2] = 16'h0000;  ws_owner[2] = 8'hFF;
		ws_page[3] = 16'hFFFF;  ws_owner[3] = 8'h00;
		for (int i = 4; i < POOL_SIZE; i++) begin
			ws_page[i] = PW'($urandom);
			ws_owner[i] = OW'($urandom);
		end
		// same page shared by two threads
		ws_page[5] = ws_page[4];
		ws_owner[5] = ws_owner[4] ^ 8'h5A;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, hit versus miss, same page under another thread
		send_request(16'h0000, 8'h00, 32'h0000_0000);
		send_request(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		send_request(16'h0000, 8'h00, 32'h0000_0005);
		send_request(16'h0000, 8'hFF, 32'h0000_0006);
		send_request(16'hFFFF, 8'h00, 32'h0000_0007);
		send_request(16'hFFFF, 8'hFF, 32'h0000_0000);
		send_request(16'hAAAA, 8'h55, 32'hAAAA_AAAA);
		send_request(16'h5555, 8'hAA, 32'h5555_5555);
		send_request(16'h0000, 8'h00, 32'h0000_0000);
		send_request(16'h5555, 8'hAA, 32'h5555_5555);

		// random: working set size moves between fitting the table and thrashing it
		hot_size = 8;
		while (sent < RUN_ITEMS) begin
			if (sent % 100 == 0)
				hot_size = $urandom_range(8, POOL_SIZE);
			random_request();
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d lookups: %0d hits, %0d misses, %0d of them evicting",
			sent, hits_seen, sent - hits_seen, evictions_seen);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
sv/ipt_pkg.sv
sv/ipt_cell.sv
sv/inverted_page_table_lru.sv
sv/ipt_checker.sv
bench/ipt_checker.sv
bench/tb.sv
